>>> src/gki_pkg.sv
`default_nettype none

package gki_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_Q_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_R_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_Q_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_R_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd6;

    localparam int PERIOD_W   = 10;
    localparam int MS_PER_S   = 1000;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_BITS_W = 32;
    localparam int DIV_STEP_W = 6;

    typedef struct packed {
        logic        [31:0]         noise_q_x;
        logic        [31:0]         noise_r_x;
        logic        [31:0]         noise_q_y;
        logic        [31:0]         noise_r_y;
        logic signed [31:0]         bias_x;
        logic signed [31:0]         bias_y;
        logic        [PERIOD_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic                  start;
        logic [DIV_DEN_W-1:0]  den;
        logic [DIV_DEN_W-1:0]  rem;
        logic [DIV_BITS_W-1:0] bits;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIV_BITS_W-1:0] quot;
    } t_div_rsp;

    // Clamp a 35-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] f_sat32(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v > 35'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/gki_if.sv
`default_nettype none

interface gki_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;

    modport source (output valid, output rate_x, output rate_y, input ready);
    modport sink   (input valid, input rate_x, input rate_y, output ready);
endinterface

interface gki_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] filtered_x;
    logic signed [31:0] filtered_y;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;

    modport source (output valid, output filtered_x, output filtered_y,
                    output angle_x, output angle_y, input ready);
    modport sink   (input valid, input filtered_x, input filtered_y,
                    input angle_x, input angle_y, output ready);
endinterface

interface gki_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gki_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/gki_cfg.sv
`default_nettype none

module gki_cfg #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    gki_cfg_if.sink            i_cfg,
    output gki_pkg::t_cfg      o_cfg
);
    import gki_pkg::*;

    localparam int ONE_I    = 2 ** FRAC_BITS;
    localparam int Q_RST    = (ONE_I + MS_PER_S / 2) / MS_PER_S;
    localparam int BIAS_RST = (ONE_I * 24) / 10;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_q_x <= 32'(Q_RST);
            r_cfg.noise_r_x <= 32'(ONE_I);
            r_cfg.noise_q_y <= 32'(Q_RST);
            r_cfg.noise_r_y <= 32'(ONE_I);
            r_cfg.bias_x    <= 32'(BIAS_RST);
            r_cfg.bias_y    <= '0;
            r_cfg.period    <= PERIOD_W'(150);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NOISE_Q_X: r_cfg.noise_q_x <= i_cfg.data;
                CFG_NOISE_R_X: r_cfg.noise_r_x <= i_cfg.data;
                CFG_NOISE_Q_Y: r_cfg.noise_q_y <= i_cfg.data;
                CFG_NOISE_R_Y: r_cfg.noise_r_y <= i_cfg.data;
                CFG_BIAS_X:    r_cfg.bias_x    <= i_cfg.data;
                CFG_BIAS_Y:    r_cfg.bias_y    <= i_cfg.data;
                CFG_PERIOD:    r_cfg.period    <= i_cfg.data[PERIOD_W-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/gki_div.sv
`default_nettype none

module gki_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gki_pkg::t_div_req i_req,
    output gki_pkg::t_div_rsp      o_rsp
);
    import gki_pkg::*;

    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_BITS_W-1:0] r_bits;
    logic [DIV_BITS_W-1:0] r_quot;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_done;

    logic [DIV_DEN_W:0]    w_trial;
    logic [DIV_DEN_W:0]    w_diff;
    logic                  w_ge;

    // Restoring step: shift in the next numerator bit, subtract if it fits
    assign w_trial = {r_rem, r_bits[DIV_BITS_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= i_req.steps;
            r_done <= 1'b0;
            r_den  <= i_req.den;
            r_rem  <= i_req.rem;
            r_bits <= i_req.bits;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - DIV_STEP_W'(1);
            r_done <= (r_cnt == DIV_STEP_W'(1));
            r_rem  <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            r_bits <= {r_bits[DIV_BITS_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_BITS_W-2:0], w_ge};
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

>>> src/gyro_kalman_tilt_integrator.sv
// Gyro tilt integrator: each input word carries an X and a Y angular rate (signed,
// FRAC_BITS fraction bits). The block adds the configured bias, runs each axis through
// a scalar Kalman filter (constant-state model, gain = P'/(P'+r)), scales the filtered
// rate by the sample period in ms over 1000 and adds it to a saturating tilt
// accumulator; one result word (both filtered rates, both angles) follows each input.
// The two axes are worked one after the other on one shared restoring divider (one
// quotient bit per cycle) and one shared multiplier under a sequencer. The divide by
// 1000 runs on the multiplier as two reciprocal multiplies, the dividend split at bit
// 21. Each axis runs the gain division, then the estimate, variance and angle steps;
// the gain division is skipped when P' + r is zero. A new word is taken only once the
// last one is through the sequencer; the input is ready again as soon as the result
// is loaded, while that result still waits to be taken. Configuration registers take
// writes at any time and must only be written while the block is idle; writes past
// the list are dropped.
`default_nettype none

module gyro_kalman_tilt_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gki_in_if.sink    i_in,
    gki_res_if.source o_res,
    gki_cfg_if.sink   i_cfg
);
    import gki_pkg::*;

    localparam logic [FRAC_BITS:0] K_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [65:0]        P_HALF = 66'(1) << (FRAC_BITS - 1);
    localparam logic [31:0]        V_ONE  = 32'(K_ONE);
    // ceil(2^38 / 1000): (x * RCP_1000) >> 38 is floor(x / 1000) for any x below 2^32
    localparam logic [32:0]        RCP_1000  = 33'd274877907;
    localparam int                 RCP_SHIFT = 38;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_DEN,
        S_GSTART,
        S_GWAIT,
        S_MULE,
        S_EST,
        S_MULV,
        S_VAR,
        S_MULA,
        S_ANUM,
        S_RCPH,
        S_REMH,
        S_RCPL,
        S_AQUO,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_axis;

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Per-axis filter state
    logic signed [31:0] r_est  [2];
    logic        [31:0] r_var  [2];
    logic signed [31:0] r_tilt [2];

    // Item and working registers
    logic signed [31:0]    r_rate [2];
    logic signed [31:0]    r_z;
    logic        [31:0]    r_pp;
    logic        [32:0]    r_den;
    logic signed [32:0]    r_e;
    logic        [FRAC_BITS:0] r_k;
    logic signed [65:0]    r_prod;

    // Angle increment: rounded magnitude, its sign, high quotient, low partial dividend
    logic        [41:0]    r_anum;
    logic                  r_aneg;
    logic        [11:0]    r_qhi;
    logic        [30:0]    r_x2;

    // Result register
    logic               r_out_valid;
    logic signed [31:0] r_out_fx;
    logic signed [31:0] r_out_fy;
    logic signed [31:0] r_out_ax;
    logic signed [31:0] r_out_ay;

    logic        [31:0] w_q;
    logic        [31:0] w_r;
    logic signed [31:0] w_bias;
    logic signed [31:0] w_est;
    logic        [32:0] w_pp_sum;
    logic signed [32:0] w_z_sum;
    logic signed [32:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic        [65:0] w_mag;
    logic        [65:0] w_rnd;
    logic signed [34:0] w_qs;
    logic signed [34:0] w_est35;
    logic signed [34:0] w_est_sum;
    logic        [65:0] w_var_rnd;
    logic        [41:0] w_anum;
    logic        [11:0] w_qhi;
    logic        [9:0]  w_qhi_k;
    logic        [9:0]  w_rem_hi;
    logic        [20:0] w_qlo;
    logic signed [34:0] w_inc;
    logic signed [34:0] w_tilt35;
    logic signed [34:0] w_tilt_sum;
    logic               w_load_out;

    gki_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    gki_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Select the configuration and state of the axis at work
    assign w_q    = r_axis ? w_cfg.noise_q_y : w_cfg.noise_q_x;
    assign w_r    = r_axis ? w_cfg.noise_r_y : w_cfg.noise_r_x;
    assign w_bias = r_axis ? w_cfg.bias_y    : w_cfg.bias_x;
    assign w_est  = r_est[r_axis];

    // Prediction: biased rate and predicted variance, both saturating
    assign w_z_sum  = 33'(r_rate[r_axis]) + 33'(w_bias);
    assign w_pp_sum = {1'b0, r_var[r_axis]} + {1'b0, w_q};

    // Shared multiplier operands
    always_comb begin
        case (r_state)
            S_MULV: begin
                w_mul_a = $signed({{(32 - FRAC_BITS){1'b0}}, K_ONE - r_k});
                w_mul_b = $signed({1'b0, r_pp});
            end
            S_MULA: begin
                w_mul_a = 33'(w_est);
                w_mul_b = $signed({{(33 - PERIOD_W){1'b0}}, w_cfg.period});
            end
            S_RCPH: begin
                w_mul_a = $signed({12'b0, r_anum[41:21]});
                w_mul_b = $signed(RCP_1000);
            end
            S_RCPL: begin
                w_mul_a = $signed({2'b0, r_x2});
                w_mul_b = $signed(RCP_1000);
            end
            default: begin
                w_mul_a = r_e;
                w_mul_b = $signed({{(32 - FRAC_BITS){1'b0}}, r_k});
            end
        endcase
    end

    // Estimate step: K * e / ONE rounded half away from zero
    assign w_mag     = r_prod[65] ? 66'(-r_prod) : 66'(r_prod);
    assign w_rnd     = w_mag + P_HALF;
    assign w_qs      = $signed({1'b0, w_rnd[FRAC_BITS+33:FRAC_BITS]});
    assign w_est35   = 35'(w_est);
    assign w_est_sum = r_prod[65] ? (w_est35 - w_qs) : (w_est35 + w_qs);

    // Variance update: (ONE - K) * P' / ONE rounded half up
    assign w_var_rnd = 66'(r_prod) + P_HALF;

    // Angle increment: (|est * period| + 500) / 1000, high 21 bits first, then the
    // remainder joined to the low 21 bits; the remainder is below 1000, so ten bits do
    assign w_anum     = w_mag[41:0] + 42'(MS_PER_S / 2);
    assign w_qhi      = r_prod[RCP_SHIFT+11:RCP_SHIFT];
    assign w_qhi_k    = w_qhi[9:0] * 10'(MS_PER_S);
    assign w_rem_hi   = r_anum[30:21] - w_qhi_k;
    assign w_qlo      = r_prod[RCP_SHIFT+20:RCP_SHIFT];
    assign w_inc      = $signed({2'b0, r_qhi, w_qlo});
    assign w_tilt35   = 35'(r_tilt[r_axis]);
    assign w_tilt_sum = r_aneg ? (w_tilt35 - w_inc) : (w_tilt35 + w_inc);

    // Divider request: gain division
    always_comb begin
        // Preload P' >> 1 so that the first step compares P' against the divisor
        w_div_req.start = (r_state == S_GSTART) && (r_den != '0);
        w_div_req.den   = r_den;
        w_div_req.rem   = {2'b0, r_pp[31:1]};
        w_div_req.bits  = {r_pp[0], 31'b0};
        w_div_req.steps = DIV_STEP_W'(FRAC_BITS + 1);
    end

    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_est[i]  <= '0;
                r_var[i]  <= V_ONE;
                r_tilt[i] <= '0;
            end
        end else begin
            // Load a finished word, or release the held one once taken
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_rate[0] <= i_in.rate_x;
                        r_rate[1] <= i_in.rate_y;
                        r_axis    <= 1'b0;
                        r_state   <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_z     <= f_sat32(35'(w_z_sum));
                    r_pp    <= w_pp_sum[32] ? 32'hFFFF_FFFF : w_pp_sum[31:0];
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den   <= {1'b0, r_pp} + {1'b0, w_r};
                    r_e     <= 33'(r_z) - 33'(w_est);
                    r_state <= S_GSTART;
                end
                S_GSTART: begin
                    // Zero divisor: gain is zero and the state holds
                    if (r_den == '0) begin
                        r_k     <= '0;
                        r_state <= S_MULE;
                    end else begin
                        r_state <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (w_div_rsp.done) begin
                        r_k     <= w_div_rsp.quot[FRAC_BITS:0];
                        r_state <= S_MULE;
                    end
                end
                S_MULE: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_EST;
                end
                S_EST: begin
                    r_est[r_axis] <= f_sat32(w_est_sum);
                    r_state       <= S_MULV;
                end
                S_MULV: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    if (r_den != '0) begin
                        r_var[r_axis] <= w_var_rnd[FRAC_BITS+31:FRAC_BITS];
                    end
                    r_state <= S_MULA;
                end
                S_MULA: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_ANUM;
                end
                S_ANUM: begin
                    r_anum  <= w_anum;
                    r_aneg  <= r_prod[65];
                    r_state <= S_RCPH;
                end
                S_RCPH: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_REMH;
                end
                S_REMH: begin
                    r_qhi   <= w_qhi;
                    r_x2    <= {w_rem_hi, r_anum[20:0]};
                    r_state <= S_RCPL;
                end
                S_RCPL: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_state <= S_AQUO;
                end
                S_AQUO: begin
                    r_tilt[r_axis] <= f_sat32(w_tilt_sum);
                    if (r_axis == 1'b0) begin
                        r_axis  <= 1'b1;
                        r_state <= S_PRED;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold here until the result register is free
                    if (w_load_out) begin
                        r_out_fx <= r_est[0];
                        r_out_fy <= r_est[1];
                        r_out_ax <= r_tilt[0];
                        r_out_ay <= r_tilt[1];
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.filtered_x = r_out_fx;
    assign o_res.filtered_y = r_out_fy;
    assign o_res.angle_x    = r_out_ax;
    assign o_res.angle_y    = r_out_ay;

    // The divider never runs while a new word can be taken
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.busy |-> !i_in.ready)
        else $error("divider busy while input ready");

    // A quotient only ever arrives while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_GWAIT))
        else $error("divider result with no waiting state");

    // The gain never exceeds one
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULE) |-> (r_k <= K_ONE))
        else $error("gain above one");

endmodule

`default_nettype wire
